@@ sv/sfl_pkg.sv @@
package sfl_pkg;

  // default configuration
  localparam int TAPS_DEF        = 32;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed field widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int LEVEL_W  = 16;
  localparam int GAIN_W   = 15;
  localparam int ACC_W    = 64;
  localparam int MUL_W    = 33;
  localparam int HI_SHIFT = 32;

  // fixed-point constants
  localparam logic [GAIN_W-1:0] LEVEL_MAX = 15'h7FFF;
  localparam int LEVEL_SHIFT = 15;
  localparam int FIR_SHIFT   = 31;

  // apb register map
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_FILTER_ON   = 2'd0;
  localparam logic [1:0] REG_LEFT_LEVEL  = 2'd1;
  localparam logic [1:0] REG_RIGHT_LEVEL = 2'd2;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_COEF  = 2'd2;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [5:0]                 coeff_index;
    logic signed [COEF_W-1:0]   coeff_value;
  } sfl_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } sfl_result_t;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic acc_hi;
  } sfl_mac_ctl_t;

  // gain clamp to 0x7FFF
  function automatic logic [GAIN_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv);
    return lv[LEVEL_W-1] ? LEVEL_MAX : lv[GAIN_W-1:0];
  endfunction

endpackage

@@ sv/sfl_ram.sv @@
module sfl_ram #(
  parameter int WIDTH = sfl_pkg::COEF_W,
  parameter int DEPTH = 2 * sfl_pkg::TAPS_DEF
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sfl_mac.sv @@
module sfl_mac (
  input  logic                                clk,
  input  sfl_pkg::sfl_mac_ctl_t               ctl,
  input  logic signed [sfl_pkg::MUL_W-1:0]    op_a,
  input  logic signed [sfl_pkg::MUL_W-1:0]    op_b,
  output logic signed [sfl_pkg::ACC_W-1:0]    acc
);

  import sfl_pkg::*;

  logic signed [2*MUL_W-1:0] prod_full;
  logic signed [ACC_W-1:0]   prod;

  assign prod_full = op_a * op_b;

  // product register, then wrapping accumulate (optionally upper word)
  always_ff @(posedge clk) begin
    prod <= prod_full[ACC_W-1:0];
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + (ctl.acc_hi ? (prod << HI_SHIFT) : prod);
    end
  end

endmodule

@@ sv/stereo_fir_with_level_scaling.sv @@
// A tick or a clear gives one result; a coefficient write gives no result.
// Items are stalled while a tick or clear is in progress; with the filter on, the one
//   shared 33x33 multiply-accumulate unit steps through every tap of both channels.
// Coefficient writes and unused codes are taken one per cycle while the block is idle.
// Reset is synchronous: control and config registers, valid bits
//   (delay lines and coefficients read zero).
module stereo_fir_with_level_scaling #(
  parameter int TAPS        = sfl_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  sfl_pkg::sfl_item_t            item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output sfl_pkg::sfl_result_t          result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfl_pkg::APB_AW-1:0]    paddr,
  input  logic [sfl_pkg::APB_DW-1:0]    pwdata,
  output logic [sfl_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import sfl_pkg::*;

  localparam int COEF_DEPTH = 2 * TAPS;
  localparam int TAP_AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int CNT_W      = $clog2(TAPS + 1);
  localparam int IDX_CMP_W  = ($clog2(COEF_DEPTH + 1) > 6) ? $clog2(COEF_DEPTH + 1) : 6;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC_L = 6'b000010,
    S_MAC_R = 6'b000100,
    S_SCL_L = 6'b001000,
    S_SCL_R = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic                          filter_on;
  logic [LEVEL_W-1:0]            left_level;
  logic [LEVEL_W-1:0]            right_level;

  logic [COEF_DEPTH-1:0]         coef_vld;
  logic [TAPS-1:0]               dly_vld;
  logic [TAP_AW-1:0]             wp;
  logic [TAP_AW-1:0]             da;
  logic [COEF_AW-1:0]            cidx;
  logic [CNT_W-1:0]              cnt;
  logic                          rd_v;
  logic                          mul_v;
  logic                          coef_rv;
  logic                          dly_rv;
  logic [1:0]                    sc;
  logic signed [ACC_W-1:0]       vl;
  logic signed [ACC_W-1:0]       vr;
  logic signed [SAMPLE_W-1:0]    res_l;
  logic signed [SAMPLE_W-1:0]    res_r;

  logic                          accept;
  logic                          in_mac;
  logic                          in_scl;
  logic                          issue;
  logic                          drained;
  logic                          idx_ok;
  logic [TAP_AW-1:0]             np;
  logic [TAP_AW-1:0]             da_dec;
  logic signed [SAMPLE_BITS-1:0] l_in;
  logic signed [SAMPLE_BITS-1:0] r_in;
  logic                          dly_we;
  logic                          coef_we;
  logic [2*SAMPLE_BITS-1:0]      dly_q;
  logic signed [COEF_W-1:0]      coef_q;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [ACC_W-1:0]       vsel;
  logic [GAIN_W-1:0]             gsel;
  logic signed [MUL_W-1:0]       op_a;
  logic signed [MUL_W-1:0]       op_b;
  sfl_mac_ctl_t                  mac_ctl;
  logic signed [ACC_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] scl_w;
  logic signed [SAMPLE_W-1:0]    res_next;
  logic signed [ACC_W-1:0]       fir_val;
  logic                          cfg_we;

  // handshake
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;

  // sequencer phase decode
  assign in_mac  = (state == S_MAC_L) || (state == S_MAC_R);
  assign in_scl  = (state == S_SCL_L) || (state == S_SCL_R);
  assign issue   = in_mac && (cnt != CNT_W'(TAPS));
  assign drained = (cnt == CNT_W'(TAPS)) && !rd_v && !mul_v;

  // circular delay line pointers
  assign np     = (wp == TAP_AW'(TAPS - 1)) ? '0 : wp + 1'b1;
  assign da_dec = (da == '0) ? TAP_AW'(TAPS - 1) : da - 1'b1;

  // input samples wrapped to the sample width
  assign l_in = SAMPLE_BITS'(item.left_sample);
  assign r_in = SAMPLE_BITS'(item.right_sample);

  assign idx_ok  = IDX_CMP_W'(item.coeff_index) < IDX_CMP_W'(COEF_DEPTH);
  assign dly_we  = accept && (item.func == FUNC_TICK) && filter_on;
  assign coef_we = accept && (item.func == FUNC_COEF) && idx_ok;

  sfl_ram #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(TAPS)
  ) u_dly_ram (
    .clk  (clk),
    .we   (dly_we),
    .waddr(np),
    .wdata({l_in, r_in}),
    .raddr(da),
    .rdata(dly_q)
  );

  sfl_ram #(
    .WIDTH(COEF_W),
    .DEPTH(COEF_DEPTH)
  ) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(COEF_AW'(item.coeff_index)),
    .wdata(item.coeff_value),
    .raddr(cidx),
    .rdata(coef_q)
  );

  // operand select for the shared multiplier
  assign samp = (state == S_MAC_L) ? dly_q[2*SAMPLE_BITS-1:SAMPLE_BITS]
                                   : dly_q[SAMPLE_BITS-1:0];
  assign vsel = (state == S_SCL_L) ? vl : vr;
  assign gsel = clamp_level((state == S_SCL_L) ? left_level : right_level);

  always_comb begin
    if (in_mac) begin
      op_a = coef_rv ? MUL_W'(coef_q) : '0;
      op_b = dly_rv ? MUL_W'(samp) : '0;
    end else begin
      op_a = (sc == 2'd0) ? {1'b0, vsel[HI_SHIFT-1:0]} : {1'b0, vsel[ACC_W-1:HI_SHIFT]};
      op_b = {{(MUL_W-GAIN_W){1'b0}}, gsel};
    end
  end

  // accumulator control
  always_comb begin
    mac_ctl.acc_clr = accept || (in_mac && drained) || (in_scl && (sc == 2'd3));
    mac_ctl.acc_en  = (in_mac && mul_v) || (in_scl && ((sc == 2'd1) || (sc == 2'd2)));
    mac_ctl.acc_hi  = in_scl && (sc == 2'd2);
  end

  sfl_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .op_a(op_a),
    .op_b(op_b),
    .acc (acc)
  );

  // filter output and scaled, wrapped result
  assign fir_val  = acc >>> FIR_SHIFT;
  assign scl_w    = acc[LEVEL_SHIFT +: SAMPLE_BITS];
  assign res_next = SAMPLE_W'(scl_w);

  // read-side valid flags travel with the registered ram data
  always_ff @(posedge clk) begin
    if (issue) begin
      coef_rv <= coef_vld[cidx];
      dly_rv  <= dly_vld[da];
    end
  end

  // sequencer, config registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_v         <= 1'b0;
      mul_v        <= 1'b0;
      result_valid <= 1'b0;
      filter_on    <= 1'b0;
      left_level   <= '0;
      right_level  <= '0;
      coef_vld     <= '0;
      dly_vld      <= '0;
      wp           <= '0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;

      if (issue) begin
        cnt  <= cnt + 1'b1;
        cidx <= cidx + 1'b1;
        da   <= da_dec;
      end

      // config writes
      if (cfg_we) begin
        case (paddr[APB_AW-1:2])
          REG_FILTER_ON:   filter_on   <= pwdata[0];
          REG_LEFT_LEVEL:  left_level  <= pwdata[LEVEL_W-1:0];
          REG_RIGHT_LEVEL: right_level <= pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end

      // result taken downstream, the done state reloads it itself
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.func)
              FUNC_TICK: begin
                cnt  <= '0;
                cidx <= '0;
                sc   <= '0;
                if (filter_on) begin
                  wp          <= np;
                  da          <= np;
                  dly_vld[np] <= 1'b1;
                  state       <= S_MAC_L;
                end else begin
                  vl    <= ACC_W'(l_in);
                  vr    <= ACC_W'(r_in);
                  state <= S_SCL_L;
                end
              end
              FUNC_CLEAR: begin
                dly_vld <= '0;
                res_l   <= '0;
                res_r   <= '0;
                state   <= S_DONE;
              end
              FUNC_COEF: begin
                if (idx_ok) begin
                  coef_vld[COEF_AW'(item.coeff_index)] <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_MAC_L: begin
          if (drained) begin
            vl    <= fir_val;
            cnt   <= '0;
            state <= S_MAC_R;
          end
        end
        S_MAC_R: begin
          if (drained) begin
            vr    <= fir_val;
            sc    <= '0;
            state <= S_SCL_L;
          end
        end
        S_SCL_L: begin
          sc <= sc + 1'b1;
          if (sc == 2'd3) begin
            res_l <= res_next;
            state <= S_SCL_R;
          end
        end
        S_SCL_R: begin
          sc <= sc + 1'b1;
          if (sc == 2'd3) begin
            res_r <= res_next;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result.left_out  <= res_l;
            result.right_out <= res_r;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (paddr[APB_AW-1:2])
      REG_FILTER_ON:   prdata = {{(APB_DW-1){1'b0}}, filter_on};
      REG_LEFT_LEVEL:  prdata = {{(APB_DW-LEVEL_W){1'b0}}, left_level};
      REG_RIGHT_LEVEL: prdata = {{(APB_DW-LEVEL_W){1'b0}}, right_level};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ sv/sfl_checker.sv @@
module sfl_assertions (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input sfl_pkg::sfl_item_t            item,
  input logic                          result_valid,
  input logic                          result_stall,
  input sfl_pkg::sfl_result_t          result,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [sfl_pkg::APB_AW-1:0]    paddr,
  input logic [sfl_pkg::APB_DW-1:0]    pwdata,
  input logic [sfl_pkg::APB_DW-1:0]    prdata,
  input logic                          pready
);

  import sfl_pkg::*;

  // a stalled result transaction holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("result changed while stalled");

  // a sample tick keeps the block busy on the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (item.func == FUNC_TICK)) |=> item_stall)
    else $error("block not busy after tick");

  // a coefficient write does not occupy the sequencer
  a_coef_free: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (item.func == FUNC_COEF)) |=> !item_stall)
    else $error("block busy after coefficient write");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!result_valid && !item_stall))
    else $error("not idle after reset");

  // a new result only appears at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result without work in progress");

endmodule

bind stereo_fir_with_level_scaling sfl_assertions u_sfl_checker (.*);
